// File: rtl/gray_gradient_edge_threshold_assert.svh
// Assertion macros shared by the gray gradient edge threshold RTL.
`ifndef GRAY_GRADIENT_EDGE_THRESHOLD_ASSERT_SVH
`define GRAY_GRADIENT_EDGE_THRESHOLD_ASSERT_SVH
`ifndef SYNTHESIS
`define GGE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gray gradient edge threshold: assertion failed");
`define GGE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `GGE_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`define GGE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `GGE_ASSERT(lbl, clk, rstn, (ante) |=> (cons))
`else
`define GGE_ASSERT(lbl, clk, rstn, prop)
`define GGE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GGE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/ggedge_pkg.sv
// Shared types and constants of the gray gradient edge threshold block.
package ggedge_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // Luma weights in percent and the reciprocal of 100 used for the floor division.
  localparam int GRAY_WR     = 30;
  localparam int GRAY_WG     = 59;
  localparam int GRAY_WB     = 11;
  localparam int GRAY_RECIP  = 41944;
  localparam int GRAY_SHIFT  = 22;

  localparam logic [7:0] PIX_EDGE = 8'd0;
  localparam logic [7:0] PIX_FLAT = 8'd255;

  localparam int OUT_FIFO_DEPTH = 8;

  typedef struct packed {
    logic [7:0] pixel;
    logic       outv;
    logic       last;
  } result_t;

endpackage

// File: rtl/ggedge_ram.sv
// Generic simple dual-port RAM with a registered, read-first read port.
module ggedge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ggedge_fifo.sv
// Output result queue that also serves as the output register.
`include "gray_gradient_edge_threshold_assert.svh"

module ggedge_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ggedge_pkg::result_t push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output ggedge_pkg::result_t data_o
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  ggedge_pkg::result_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0] count_q;
  logic           full;

  assign full    = (count_q == CNW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNW'(1);
      end
    end
  end

  `GGE_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full || pop_i)
  `GGE_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, count_q != '0)
  `GGE_ASSERT_NEXT(a_pop_drops, clk_i, rst_ni, pop_i && !push_i, count_q == $past(count_q) - CNW'(1))

endmodule

// File: rtl/gray_gradient_edge_threshold.sv
// Top level: streaming gray conversion and central difference edge threshold.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   red_i green_i blue_i drain_i
//   result    output     res_valid_o / res_ready_i pixel_out_o out_valid_o frame_last_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// One pixel per clock is taken unless the input stalls; s1, s2 and s3 register a result
// before the output queue. Throughput is set by the single read-modify-write pass over
// the two line RAMs (one per row parity): each item reads both, a pixel writes its row's.
// Reset sets counters and control registers at once; the line RAMs need no clearing pass.
// Up to eight results are buffered; input stalls only when eight are in flight.
`include "gray_gradient_edge_threshold_assert.svh"

module gray_gradient_edge_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          red_i,
  input  logic [7:0]                          green_i,
  input  logic [7:0]                          blue_i,
  input  logic                                drain_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [7:0]                          pixel_out_o,
  output logic                                out_valid_o,
  output logic                                frame_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ggedge_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ggedge_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RW      = $clog2(MAX_HEIGHT + 1);
  localparam int W_RESET = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int H_RESET = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;
  localparam int FD      = ggedge_pkg::OUT_FIFO_DEPTH;
  localparam int PNW     = $clog2(FD + 1);

  typedef struct packed {
    logic          vld;
    logic          ok;
    logic          pix;
    logic          outv;
    logic          border;
    logic          last;
    logic          first;
    logic          fwd;
    logic          par;
    logic [CW-1:0] col;
  } s1_t;

  typedef struct packed {
    logic vld;
    logic pix;
    logic outv;
    logic border;
    logic last;
  } s_ctl_t;

  // ---------------- configuration ----------------
  logic [17:0]   thr_q;
  logic [WW-1:0] w_q, wm1_q, w_cfg;
  logic [RW-1:0] h_q, h_cfg;
  logic [15:0]   thr_sq;
  logic          geo_wr;

  assign cfg_ready_o = 1'b1;
  assign thr_sq      = 16'(cfg_data_i[7:0]) * 16'(cfg_data_i[7:0]);
  assign geo_wr      = cfg_valid_i && ((cfg_index_i == ggedge_pkg::CFG_WIDTH) ||
                                       (cfg_index_i == ggedge_pkg::CFG_HEIGHT));

  // A zero dimension acts as one, an oversized one as the maximum.
  always_comb begin
    if (cfg_data_i == '0) begin
      w_cfg = WW'(1);
      h_cfg = RW'(1);
    end else begin
      w_cfg = (32'(cfg_data_i) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_data_i);
      h_cfg = (32'(cfg_data_i) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      w_q   <= WW'(W_RESET);
      wm1_q <= WW'(W_RESET - 1);
      h_q   <= RW'(H_RESET);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ggedge_pkg::CFG_THRESHOLD: thr_q <= {thr_sq, 2'b00};
        ggedge_pkg::CFG_WIDTH: begin
          w_q   <= w_cfg;
          wm1_q <= w_cfg - WW'(1);
        end
        ggedge_pkg::CFG_HEIGHT: h_q <= h_cfg;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: raster position and RAM reads ----------------
  logic [CW-1:0]  col_q, c0, c0_p1;
  logic [RW-1:0]  row_q, r0;
  logic [PNW-1:0] pend_q;
  logic           accept, pop, wrap, drain_row, ok0, last_col0, fwd0;
  logic [14:0]    sum0;
  s1_t            s1_q;
  logic [14:0]    sum1_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (pend_q != PNW'(FD));
  assign wrap       = (WW'(col_q) >= w_q) || (row_q > h_q);
  assign c0         = wrap ? '0 : col_q;
  assign r0         = wrap ? '0 : row_q;
  assign c0_p1      = c0 + CW'(1);
  assign drain_row  = (r0 == h_q);
  assign ok0        = (drain_i == drain_row);
  assign last_col0  = (WW'(c0) == wm1_q);
  assign sum0       = 15'(red_i) * 15'(ggedge_pkg::GRAY_WR)
                    + 15'(green_i) * 15'(ggedge_pkg::GRAY_WG)
                    + 15'(blue_i) * 15'(ggedge_pkg::GRAY_WB);

  // The right neighbor on the previous row may still be in flight from the item just ahead.
  assign fwd0 = s1_q.vld && s1_q.pix && (s1_q.par != r0[0]) && (s1_q.col == c0_p1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (geo_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (!ok0) begin
        col_q <= c0;
        row_q <= r0;
      end else if (last_col0) begin
        col_q <= '0;
        row_q <= drain_row ? '0 : r0 + RW'(1);
      end else begin
        col_q <= c0_p1;
        row_q <= r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q.vld    <= accept;
      s1_q.ok     <= accept && ok0;
      s1_q.pix    <= accept && ok0 && !drain_i;
      s1_q.outv   <= ok0 && (r0 != '0);
      s1_q.border <= (r0 == RW'(1)) || drain_row || (c0 == '0) || last_col0;
      s1_q.last   <= ok0 && drain_i && last_col0;
      s1_q.first  <= (c0 == '0);
      s1_q.fwd    <= accept && fwd0;
      s1_q.par    <= r0[0];
      s1_q.col    <= c0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum1_q <= sum0;
    end
  end

  // ---------------- line RAMs, one per row parity ----------------
  logic [7:0] rdata [2];
  logic [7:0] gray1;

  for (genvar gi = 0; gi < 2; gi++) begin : g_line
    ggedge_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
    ) u_line_ram (
      .clk_i   (clk_i),
      .we_i    (s1_q.pix && (s1_q.par == 1'(gi))),
      .waddr_i (s1_q.col),
      .wdata_i (gray1),
      .re_i    (accept),
      .raddr_i ((r0[0] == 1'(gi)) ? c0 : c0_p1),
      .rdata_o (rdata[gi])
    );
  end

  // ---------------- stage 1: gray value and neighbor window ----------------
  logic [30:0] prod1;
  logic [7:0]  above1, right1, center1;
  logic [7:0]  first_q, left_q, mid_q;
  logic [7:0]  gray2_q, above2_q, left2_q, right2_q, center2_q;
  s_ctl_t      s2_q;

  assign prod1   = 31'(sum1_q) * 31'(ggedge_pkg::GRAY_RECIP);
  assign gray1   = prod1[ggedge_pkg::GRAY_SHIFT +: 8];
  assign above1  = s1_q.par ? rdata[1] : rdata[0];
  assign right1  = s1_q.fwd ? gray2_q : (s1_q.par ? rdata[0] : rdata[1]);
  assign center1 = s1_q.first ? first_q : mid_q;

  always_ff @(posedge clk_i) begin
    if (s1_q.ok) begin
      left_q <= center1;
      mid_q  <= right1;
    end
    if (s1_q.pix && s1_q.first) begin
      first_q <= gray1;
    end
    gray2_q   <= gray1;
    above2_q  <= above1;
    left2_q   <= left_q;
    right2_q  <= right1;
    center2_q <= center1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q.vld    <= s1_q.vld;
      s2_q.pix    <= s1_q.pix;
      s2_q.outv   <= s1_q.outv;
      s2_q.border <= s1_q.border;
      s2_q.last   <= s1_q.last;
    end
  end

  // ---------------- stage 2: differences and squares ----------------
  logic signed [8:0]  dx2, dy2;
  logic signed [17:0] sqx_full, sqy_full;
  logic [15:0]        sqx3_q, sqy3_q;
  logic [7:0]         center3_q;
  s_ctl_t             s3_q;

  assign dx2      = $signed({1'b0, right2_q}) - $signed({1'b0, left2_q});
  assign dy2      = $signed({1'b0, gray2_q}) - $signed({1'b0, above2_q});
  assign sqx_full = dx2 * dx2;
  assign sqy_full = dy2 * dy2;

  always_ff @(posedge clk_i) begin
    sqx3_q    <= sqx_full[15:0];
    sqy3_q    <= sqy_full[15:0];
    center3_q <= center2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= s2_q;
    end
  end

  // ---------------- stage 3: threshold and result ----------------
  logic [16:0]         mag3;
  logic                edge3;
  ggedge_pkg::result_t res3, res_out;

  assign mag3  = {1'b0, sqx3_q} + {1'b0, sqy3_q};
  assign edge3 = ({1'b0, mag3} > thr_q);

  always_comb begin
    res3.outv = s3_q.outv;
    res3.last = s3_q.last;
    if (!s3_q.outv) begin
      res3.pixel = 8'd0;
    end else if (s3_q.border) begin
      res3.pixel = center3_q;
    end else begin
      res3.pixel = edge3 ? ggedge_pkg::PIX_EDGE : ggedge_pkg::PIX_FLAT;
    end
  end

  assign pop = res_valid_o && res_ready_i;

  ggedge_fifo #(
    .DEPTH (FD)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_q.vld),
    .push_data_i (res3),
    .pop_i       (pop),
    .valid_o     (res_valid_o),
    .data_o      (res_out)
  );

  assign pixel_out_o  = res_out.pixel;
  assign out_valid_o  = res_out.outv;
  assign frame_last_o = res_out.last;

  // Transactions accepted whose results have not yet left the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (accept && !pop) begin
      pend_q <= pend_q + PNW'(1);
    end else if (pop && !accept) begin
      pend_q <= pend_q - PNW'(1);
    end
  end

  `GGE_ASSERT_IMP(a_fwd_source, clk_i, rst_ni, s1_q.fwd, s2_q.vld && s2_q.pix)
  `GGE_ASSERT_IMP(a_pos_in_frame, clk_i, rst_ni, accept, (WW'(col_q) < w_q) && (row_q <= h_q))
  `GGE_ASSERT_IMP(a_write_in_row, clk_i, rst_ni, s1_q.pix, WW'(s1_q.col) < w_q)
  `GGE_ASSERT_IMP(a_last_is_output, clk_i, rst_ni, s3_q.vld && s3_q.last, s3_q.outv)

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the gray gradient edge threshold block.
module testbench;

  localparam int MAX_W  = 1024;
  localparam int MAX_H  = 1024;
  localparam int IDX_W  = ggedge_pkg::CFG_IDX_W;
  localparam int DATA_W = ggedge_pkg::CFG_DATA_W;
  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {STYLE_NOISE, STYLE_EXTREME, STYLE_SMOOTH, STYLE_ROUGH} pixel_style_e;

  // Colors of the 4x3 directed frame, raster order, packed as {red, green, blue}.
  localparam logic [23:0] DIRECTED_FRAME [12] = '{
    24'hFFFFFF, 24'h000000, 24'h0A0000, 24'h0000FF,
    24'h646464, 24'h00FF00, 24'h646464, 24'h010203,
    24'hC8C8C8, 24'h000000, 24'h646464, 24'hFFFFFF
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        red_i = '0;
  logic [7:0]        green_i = '0;
  logic [7:0]        blue_i = '0;
  logic              drain_i = 1'b0;
  logic              res_valid_o;
  logic              res_ready_i = 1'b0;
  logic [7:0]        pixel_out_o;
  logic              out_valid_o;
  logic              frame_last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  // Mirror of the block's state: line store, raster position and registers.
  bit [7:0]    gray_lines [2*MAX_W];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned edge_thr = 0;
  int unsigned img_w = 1024;
  int unsigned img_h = 1024;

  ggedge_pkg::result_t pending_pixels [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_pixels = 0;
  int unsigned n_drains = 0;
  int unsigned n_ignored = 0;
  int unsigned n_frames = 0;
  int unsigned n_writes = 0;

  gray_gradient_edge_threshold #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .drain_i     (drain_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .pixel_out_o (pixel_out_o),
    .out_valid_o (out_valid_o),
    .frame_last_o(frame_last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Computes the output pixel for one accepted item and advances the mirrored state.
  function automatic ggedge_pkg::result_t predict_edge_pixel(input logic [7:0] r,
                                                             input logic [7:0] g,
                                                             input logic [7:0] b,
                                                             input logic d,
                                                             output bit ignored);
    int unsigned w, h, c, row, gray, above, base, mag, limit;
    int dx, dy;
    ggedge_pkg::result_t res;
    w = (img_w == 0) ? 1 : (img_w > MAX_W) ? MAX_W : img_w;
    h = (img_h == 0) ? 1 : (img_h > MAX_H) ? MAX_H : img_h;
    res = '0;
    ignored = 1'b0;
    gray = 0;
    above = 0;
    if (col_pos >= w || row_pos > h) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    row = row_pos;
    // Flush items amid pixels, or pixels amid flushing, give a result with outv low.
    if (d != (row == h)) begin
      ignored = 1'b1;
      return res;
    end
    if (!d) begin
      gray = (30 * r + 59 * g + 11 * b) / 100;
      above = gray_lines[(row % 2) * MAX_W + c];
      gray_lines[(row % 2) * MAX_W + c] = gray[7:0];
    end
    if (row >= 1) begin
      base = ((row - 1) % 2) * MAX_W;
      res.outv = 1'b1;
      if (row - 1 == 0 || row - 1 == h - 1 || c == 0 || c == w - 1) begin
        res.pixel = gray_lines[base + c];
      end else begin
        dx = int'(gray_lines[base + c + 1]) - int'(gray_lines[base + c - 1]);
        dy = int'(gray) - int'(above);
        mag = dx * dx + dy * dy;
        limit = 4 * edge_thr * edge_thr;
        res.pixel = (mag > limit) ? ggedge_pkg::PIX_EDGE : ggedge_pkg::PIX_FLAT;
      end
      res.last = d && (c == w - 1);
    end
    c++;
    if (c >= w) begin
      c = 0;
      row++;
      if (row > h) row = 0;
    end
    col_pos = c;
    row_pos = row;
    return res;
  endfunction

  // Receiver: compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    ggedge_pkg::result_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_error("result transaction with nothing expected");
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (pixel_out_o !== want.pixel)
          report_error($sformatf("pixel_out %0d, expected %0d", pixel_out_o, want.pixel));
        if (out_valid_o !== want.outv)
          report_error($sformatf("out_valid %b, expected %b", out_valid_o, want.outv));
        if (frame_last_o !== want.last)
          report_error($sformatf("frame_last %b, expected %b", frame_last_o, want.last));
      end
    end
    res_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic d);
    ggedge_pkg::result_t res;
    bit ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    drain_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = predict_edge_pixel(r, g, b, d, ignored);
    pending_pixels.push_back(res);
    if (ignored) n_ignored++;
    else if (d) n_drains++;
    else n_pixels++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ggedge_pkg::CFG_THRESHOLD: edge_thr = data[7:0];
      ggedge_pkg::CFG_WIDTH: begin
        img_w = data;
        col_pos = 0;
        row_pos = 0;
      end
      ggedge_pkg::CFG_HEIGHT: begin
        img_h = data;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    n_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [DATA_W-1:0] w_data,
                              input logic [DATA_W-1:0] h_data);
    wait_for_results();
    write_register(ggedge_pkg::CFG_WIDTH, w_data);
    write_register(ggedge_pkg::CFG_HEIGHT, h_data);
  endtask

  function automatic logic [DATA_W-1:0] pick_threshold();
    logic [2:0] upper;
    logic [7:0] t;
    upper = 3'($urandom_range(7));
    case ($urandom_range(6))
      0: t = 8'd0;
      1: t = 8'd255;
      default: t = 8'($urandom_range(40));
    endcase
    return {upper, t};
  endfunction

  function automatic void pick_pixel(input pixel_style_e style, input int unsigned base,
                                     output logic [7:0] r, output logic [7:0] g,
                                     output logic [7:0] b);
    int unsigned v;
    case (style)
      STYLE_NOISE: begin
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
      end
      STYLE_EXTREME: begin
        r = $urandom_range(1) ? 8'hFF : 8'h00;
        g = $urandom_range(1) ? 8'hFF : 8'h00;
        b = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: begin
        // Equal channels give an exact gray value, so small gradients stay controlled.
        v = base + $urandom_range(style == STYLE_SMOOTH ? 3 : 24);
        if (v > 255) v = 255;
        r = 8'(v);
        g = 8'(v);
        b = 8'(v);
      end
    endcase
  endfunction

  // Streams a frame, its flush row and stray items; stop_after may cut it short.
  task automatic stream_frame(input int unsigned w, input int unsigned h,
                              input pixel_style_e style, input int unsigned stop_after,
                              input int unsigned noise_pct);
    int unsigned base, k;
    logic [7:0] r, g, b;
    base = $urandom_range(255);
    for (k = 0; k < w * (h + 1) && k < stop_after; k++) begin
      pick_pixel(style, base, r, g, b);
      if ($urandom_range(99) < noise_pct) send_item(r, g, b, k < w * h);
      if ($urandom_range(99) == 0) wait_for_results();
      send_item(r, g, b, k >= w * h);
    end
    n_frames++;
  endtask

  task automatic test_reset_defaults();
    send_item(8'h00, 8'h00, 8'h00, 1'b1);
    send_item(8'h00, 8'h00, 8'h00, 1'b0);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(8'hFF, 8'h00, 8'h00, 1'b0);
    send_item(8'h00, 8'hFF, 8'h00, 1'b0);
    send_item(8'h00, 8'h00, 8'hFF, 1'b0);
  endtask

  task automatic test_directed_frame();
    int unsigned k;
    set_geometry(11'd4, 11'd3);
    write_register(ggedge_pkg::CFG_THRESHOLD, 11'h700);
    send_item(8'h12, 8'h34, 8'h56, 1'b1);
    for (k = 0; k < 12; k++) begin
      // The unused register index must not disturb the frame in progress.
      if (k == 6) begin
        wait_for_results();
        write_register(CFG_UNUSED, 11'h555);
      end
      send_item(DIRECTED_FRAME[k][23:16], DIRECTED_FRAME[k][15:8], DIRECTED_FRAME[k][7:0],
                1'b0);
    end
    send_item(8'hAA, 8'h55, 8'hAA, 1'b0);
    for (k = 0; k < 4; k++) send_item(8'h55, 8'hAA, 8'h55, 1'b1);
    n_frames++;
  endtask

  task automatic test_clamped_geometry();
    wait_for_results();
    write_register(ggedge_pkg::CFG_THRESHOLD, 11'h0FF);
    set_geometry(11'd0, 11'd2047);
    stream_frame(1, MAX_H, STYLE_ROUGH, 48, 2);
    set_geometry(11'd2047, 11'd0);
    stream_frame(MAX_W, 1, STYLE_NOISE, 48, 2);
  endtask

  task automatic test_random_frames(input int unsigned goal);
    int unsigned w, h, items, stop_after, target;
    logic [DATA_W-1:0] w_data, h_data;
    bit restart;
    pixel_style_e style;
    target = n_pixels + n_drains + goal;
    restart = 1'b1;
    w = 1;
    h = 1;
    while (n_pixels + n_drains < target) begin
      if (restart || $urandom_range(99) < 70) begin
        w = ($urandom_range(4) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
        h = $urandom_range(1, 8);
        w_data = (w == 1 && $urandom_range(1)) ? 11'd0 : DATA_W'(w);
        h_data = (h == 1 && $urandom_range(1)) ? 11'd0 : DATA_W'(h);
        set_geometry(w_data, h_data);
      end
      // Threshold and unused-index writes leave the raster position alone.
      if ($urandom_range(99) < 40) begin
        wait_for_results();
        write_register(ggedge_pkg::CFG_THRESHOLD, pick_threshold());
      end
      if ($urandom_range(99) < 5) begin
        wait_for_results();
        write_register(CFG_UNUSED, DATA_W'($urandom_range(2047)));
      end
      style = pixel_style_e'($urandom_range(3));
      items = w * (h + 1);
      stop_after = ($urandom_range(9) == 0) ? $urandom_range(items - 1) : items;
      restart = (stop_after < items);
      stream_frame(w, h, style, stop_after, 3);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 70;
    test_reset_defaults();
    test_directed_frame();
    test_random_frames(300);

    send_idle_pct = 70;
    recv_idle_pct = 38;
    test_clamped_geometry();
    test_random_frames(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(300);

    wait_for_results();
    repeat (16) @(posedge clk_i);
    $display("Ran %0d frames, %0d register writes: %0d pixels, %0d flush, %0d ignored.",
             n_frames, n_writes, n_pixels, n_drains, n_ignored);
    $display("Compared %0d results, zero and oversized geometry and thresholds included.",
             n_checked);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    repeat (400000) @(posedge clk_i);
    $display("Timed out with %0d results outstanding.", pending_pixels.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
